### design/rhdp_pkg.sv
// Shared types, table constants and fixed-point constants for the humidity pipeline.
package rhdp_pkg;

    // Centikelvin grid of the saturation vapor pressure table.
    localparam int unsigned BASE_CK     = 17316;
    localparam int unsigned STEP_CK     = 500;
    localparam int unsigned HALF_STEP   = 250;
    localparam int unsigned SVP_DEFINED = 41;

    // Table values are in units of 1e-6 hPa and fit in 30 bits.
    localparam int unsigned E_W   = 30;
    localparam int unsigned CK_W  = 16;
    localparam int unsigned D_W   = 15;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned F_W   = 9;
    localparam int unsigned DQ_W  = 19;
    localparam int unsigned Q_W   = 16;

    // Floor division by 500 through a reciprocal: exact for offsets below 20000.
    localparam logic [13:0] RECIP_500 = 14'd8389;
    localparam int unsigned RECIP_500_SH = 22;
    // Floor division by 125 through a reciprocal: exact for values below 62500.
    localparam logic [16:0] RECIP_125 = 17'd67109;
    localparam int unsigned RECIP_125_SH = 23;

    localparam logic [Q_W-1:0] ONE_Q15 = 16'h8000;

    typedef logic [E_W-1:0]  t_svp_arr [0:SVP_DEFINED-1];
    typedef logic [DQ_W-1:0] t_dq_arr  [0:SVP_DEFINED-2];
    typedef logic [F_W-1:0]  t_dr_arr  [0:SVP_DEFINED-2];

    localparam t_svp_arr SVP_TABLE = '{
        30'd34,        30'd89,        30'd220,       30'd517,       30'd1155,
        30'd2472,      30'd5080,      30'd10050,     30'd19210,     30'd35530,
        30'd63560,     30'd111100,    30'd189100,    30'd313900,    30'd508800,
        30'd807000,    30'd1254000,   30'd1911800,   30'd2862700,   30'd4214800,
        30'd6107800,   30'd8719200,   30'd12272000,  30'd17044000,  30'd23373000,
        30'd31671000,  30'd42430000,  30'd56236000,  30'd73777000,  30'd95855000,
        30'd123400000, 30'd157460000, 30'd199260000, 30'd250160000, 30'd311690000,
        30'd385560000, 30'd473670000, 30'd578090000, 30'd701130000, 30'd845280000,
        30'd1013250000
    };

    // The step between neighboring entries, split as quotient and remainder of 500.
    function automatic t_dq_arr calc_dq();
        t_dq_arr     res;
        int unsigned diff;
        for (int i = 0; i < SVP_DEFINED - 1; i++) begin
            diff   = int'(SVP_TABLE[i+1]) - int'(SVP_TABLE[i]);
            res[i] = DQ_W'(diff / STEP_CK);
        end
        return res;
    endfunction

    function automatic t_dr_arr calc_dr();
        t_dr_arr     res;
        int unsigned diff;
        for (int i = 0; i < SVP_DEFINED - 1; i++) begin
            diff   = int'(SVP_TABLE[i+1]) - int'(SVP_TABLE[i]);
            res[i] = F_W'(diff % STEP_CK);
        end
        return res;
    endfunction

    localparam t_dq_arr SVP_DQ = calc_dq();
    localparam t_dr_arr SVP_DR = calc_dr();

    typedef struct packed {
        logic [CK_W-1:0] temperature_ck;
        logic            temperature_ok;
        logic [CK_W-1:0] dewpoint_ck;
        logic            dewpoint_ok;
    } t_in_item;

    typedef struct packed {
        logic [Q_W-1:0] humidity_q15;
        logic           humidity_ok;
        logic           out_of_range;
    } t_out_item;

    // One value entering the interpolation pipeline.
    typedef struct packed {
        logic [CK_W-1:0] ck;
        logic            present;
    } t_pt_in;

    // Interpolated pressure with the value's status.
    typedef struct packed {
        logic [E_W-1:0] e;
        logic           present;
        logic           in_range;
    } t_pt_out;

    // Operands of the ratio division with the item's status.
    typedef struct packed {
        logic [E_W-1:0] e_temp;
        logic [E_W-1:0] e_dew;
        logic           ok;
        logic           oor;
    } t_div_in;

endpackage

### design/rhdp_interp.sv
// Six-stage pipeline that maps one centikelvin value to an interpolated vapor pressure.
module rhdp_interp
    import rhdp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 41
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_pt_in  i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_pt_out o_data
);

    localparam int NSTG = 6;
    localparam int USED = (TABLE_ENTRIES < int'(SVP_DEFINED)) ? TABLE_ENTRIES
                                                              : int'(SVP_DEFINED);
    localparam logic [CK_W-1:0] LOW_CK = CK_W'(BASE_CK);
    localparam logic [CK_W-1:0] TOP_CK = CK_W'(int'(BASE_CK) + int'(STEP_CK) * (USED - 1) - 1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(SVP_DEFINED - 2);

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_en;

    // Each stage advances when it is empty or the stage after it advances.
    always_comb begin
        w_en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    // Stage 1: offset from the table base and range test.
    logic [D_W-1:0] r1_d;
    logic           r1_ok, r1_inr;
    logic [CK_W-1:0] n1_off;
    assign n1_off = i_data.ck - LOW_CK;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_d   <= n1_off[D_W-1:0];
            r1_ok  <= i_data.present;
            r1_inr <= (i_data.ck >= LOW_CK) && (i_data.ck <= TOP_CK);
        end
    end

    // Stage 2: table index as the offset divided by the step.
    logic [D_W+13:0]  n2_prod;
    logic [6:0]       n2_lraw;
    logic [IDX_W-1:0] r2_l;
    logic [D_W-1:0]   r2_d;
    logic             r2_ok, r2_inr;
    assign n2_prod = (D_W+14)'(r1_d) * (D_W+14)'(RECIP_500);
    assign n2_lraw = n2_prod[RECIP_500_SH +: 7];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_l   <= (n2_lraw > 7'(MAX_IDX)) ? MAX_IDX : n2_lraw[IDX_W-1:0];
            r2_d   <= r1_d;
            r2_ok  <= r1_ok;
            r2_inr <= r1_inr;
        end
    end

    // Stage 3: fraction within the step and table reads.
    logic [D_W-1:0]  n3_base;
    logic [D_W-1:0]  n3_frac;
    logic [F_W-1:0]  r3_f;
    logic [E_W-1:0]  r3_lo;
    logic [DQ_W-1:0] r3_dq;
    logic [F_W-1:0]  r3_dr;
    logic            r3_ok, r3_inr;
    assign n3_base = D_W'(r2_l) * D_W'(STEP_CK);
    assign n3_frac = r2_d - n3_base;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_f   <= n3_frac[F_W-1:0];
            r3_lo  <= SVP_TABLE[r2_l];
            r3_dq  <= SVP_DQ[r2_l];
            r3_dr  <= SVP_DR[r2_l];
            r3_ok  <= r2_ok;
            r3_inr <= r2_inr;
        end
    end

    // Stage 4: whole-step part and rounded remainder part of the slope times fraction.
    logic [27:0]    r4_a;
    logic [17:0]    r4_b;
    logic [E_W-1:0] r4_lo;
    logic           r4_ok, r4_inr;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_a   <= 28'(r3_dq) * 28'(r3_f);
            r4_b   <= 18'(r3_dr) * 18'(r3_f) + 18'(HALF_STEP);
            r4_lo  <= r3_lo;
            r4_ok  <= r3_ok;
            r4_inr <= r3_inr;
        end
    end

    // Stage 5: whole-step part added to the low entry, and remainder part divided by 500 as a quarter divided by 125.
    logic [E_W-1:0] r5_sum;
    logic [32:0]    r5_c;
    logic           r5_ok, r5_inr;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_sum <= r4_lo + E_W'(r4_a);
            r5_c   <= 33'(r4_b[17:2]) * 33'(RECIP_125);
            r5_ok  <= r4_ok;
            r5_inr <= r4_inr;
        end
    end

    // Stage 6: final pressure.
    logic [E_W-1:0] r6_e;
    logic           r6_ok, r6_inr;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_e   <= r5_sum + E_W'(r5_c[32:RECIP_125_SH]);
            r6_ok  <= r5_ok;
            r6_inr <= r5_inr;
        end
    end

    assign o_ready         = w_en[0];
    assign o_valid         = r_v[NSTG-1];
    assign o_data.e        = r6_e;
    assign o_data.present  = r6_ok;
    assign o_data.in_range = r6_inr;

endmodule

### design/rhdp_div.sv
// Pipelined restoring divider that forms the clamped Q1.15 pressure ratio.
module rhdp_div
    import rhdp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_in   i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int STEPS = 2;
    localparam int NS    = Q_W / STEPS;
    localparam int NSTG  = NS + 2;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   w_en;

    always_comb begin
        w_en[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= (k == 0) ? i_valid : r_v[k-1];
                end
            end
        end
    end

    logic [E_W-1:0] r_rem [0:NS];
    logic [Q_W-1:0] r_low [0:NS];
    logic [Q_W-1:0] r_quo [0:NS];
    logic [E_W-1:0] r_et  [0:NS];
    logic           r_sat [0:NS];
    logic           r_ok  [0:NS];
    logic           r_oor [0:NS];

    // Stage 0: rounded numerator; the high part is below the divisor unless saturated.
    logic [E_W+Q_W-1:0] n0_num;
    assign n0_num = (E_W+Q_W)'({i_data.e_dew, 15'b0}) + (E_W+Q_W)'(i_data.e_temp[E_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rem[0] <= n0_num[E_W+Q_W-1:Q_W];
            r_low[0] <= n0_num[Q_W-1:0];
            r_quo[0] <= '0;
            r_et[0]  <= i_data.e_temp;
            r_sat[0] <= i_data.e_dew >= i_data.e_temp;
            r_ok[0]  <= i_data.ok;
            r_oor[0] <= i_data.oor;
        end
    end

    for (genvar s = 1; s <= NS; s++) begin : g_step
        logic [E_W-1:0] n_rem;
        logic [Q_W-1:0] n_low;
        logic [Q_W-1:0] n_quo;

        always_comb begin
            logic [E_W:0] w_trial;
            n_rem = r_rem[s-1];
            n_low = r_low[s-1];
            n_quo = r_quo[s-1];
            for (int j = 0; j < STEPS; j++) begin
                w_trial = {n_rem, n_low[Q_W-1]};
                n_low   = {n_low[Q_W-2:0], 1'b0};
                if (w_trial >= (E_W+1)'(r_et[s-1])) begin
                    w_trial = w_trial - (E_W+1)'(r_et[s-1]);
                    n_quo   = {n_quo[Q_W-2:0], 1'b1};
                end else begin
                    n_quo   = {n_quo[Q_W-2:0], 1'b0};
                end
                n_rem = w_trial[E_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[s]) begin
                r_rem[s] <= n_rem;
                r_low[s] <= n_low;
                r_quo[s] <= n_quo;
                r_et[s]  <= r_et[s-1];
                r_sat[s] <= r_sat[s-1];
                r_ok[s]  <= r_ok[s-1];
                r_oor[s] <= r_oor[s-1];
            end
        end
    end

    // Output register: saturation clamp and zeroing of invalid results.
    t_out_item r_out;
    t_out_item n_out;

    always_comb begin
        n_out.humidity_ok  = r_ok[NS];
        n_out.out_of_range = r_oor[NS];
        if (!r_ok[NS]) begin
            n_out.humidity_q15 = '0;
        end else if (r_sat[NS]) begin
            n_out.humidity_q15 = ONE_Q15;
        end else begin
            n_out.humidity_q15 = r_quo[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NSTG-1]) begin
            r_out <= n_out;
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_v[NSTG-1];
    assign o_data  = r_out;

endmodule

### design/rh_from_dewpoint_table_top.sv
// Top level of the relative humidity from dewpoint pipeline.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_in_data  (t_in_item)
//   output    out        o_out_valid / i_out_ready  o_out_data (t_out_item)
//
// One transfer is accepted per clock while the output side keeps up; every input
// transfer yields exactly one output transfer after six interpolation stages, one
// numerator stage, eight divider stages of two quotient bits each, and one output
// register. Reset (synchronous, active low) clears only the valid bits.
// A stall backs up stage by stage while empty stages still fill, so input
// transfers are taken until the pipeline is full.
module rh_from_dewpoint_table_top
    import rhdp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 41
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    // The temperature and dewpoint lanes see identical handshakes, so their
    // valid bits move in lockstep and the pair acts as one wide pipeline.
    t_pt_in  w_t_in, w_d_in;
    t_pt_out w_t_out, w_d_out;
    logic    w_t_ready, w_d_ready;
    logic    w_t_valid, w_d_valid;
    logic    w_div_ready;
    logic    w_div_valid;
    t_div_in w_div_in;
    logic    w_oor;

    assign w_t_in.ck      = i_in_data.temperature_ck;
    assign w_t_in.present = i_in_data.temperature_ok;
    assign w_d_in.ck      = i_in_data.dewpoint_ck;
    assign w_d_in.present = i_in_data.dewpoint_ok;

    rhdp_interp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_interp_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (w_t_ready),
        .i_data  (w_t_in),
        .o_valid (w_t_valid),
        .i_ready (w_div_ready),
        .o_data  (w_t_out)
    );

    rhdp_interp #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_interp_dew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (w_d_ready),
        .i_data  (w_d_in),
        .o_valid (w_d_valid),
        .i_ready (w_div_ready),
        .o_data  (w_d_out)
    );

    assign o_in_ready = w_t_ready & w_d_ready;

    // A value that is present but off the table makes the item out of range;
    // a missing value never does.
    assign w_oor = (w_t_out.present && !w_t_out.in_range)
                || (w_d_out.present && !w_d_out.in_range);

    assign w_div_valid     = w_t_valid & w_d_valid;
    assign w_div_in.e_temp = w_t_out.e;
    assign w_div_in.e_dew  = w_d_out.e;
    assign w_div_in.oor    = w_oor;
    assign w_div_in.ok     = w_t_out.present && w_d_out.present && !w_oor;

    rhdp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_div_ready),
        .i_data  (w_div_in),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
